FILE: design/pldc_pkg.sv
`timescale 1ns / 1ps

package pldc_pkg;

    // Payload and register widths fixed by the port definition
    localparam int FIELD_W    = 32;
    localparam int GAIN_W     = 32;
    localparam int LIMIT_W    = 31;
    localparam int CFG_DATA_W = 32;
    localparam int ADDR_W     = 5;
    localparam int REG_IDX_W  = 3;

    // Scaled product terms saturate to +/-2^61 before they are summed
    localparam int TERM_W = 63;
    localparam logic signed [TERM_W-1:0] TERM_LIM = {2'b01, {(TERM_W-2){1'b0}}};

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DEADBAND       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_WRAP     = 3'd6;

    // Reset values: 13000.0, 1000.0 and 10.0 in Q16.16
    localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST   = 31'd851968000;
    localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 31'd65536000;
    localparam logic [LIMIT_W-1:0] DEADBAND_RST       = 31'd655360;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [LIMIT_W-1:0]       output_limit;
        logic [LIMIT_W-1:0]       integral_limit;
        logic [LIMIT_W-1:0]       deadband;
        logic                     angle_wrap_enable;
    } pldc_cfg_t;

endpackage

FILE: design/pldc_regs.sv
`timescale 1ns / 1ps

module pldc_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pldc_pkg::ADDR_W-1:0]       paddr,
    input  logic [pldc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [pldc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output pldc_pkg::pldc_cfg_t               cfg
);
    import pldc_pkg::*;

    pldc_cfg_t             cfg_reg;
    pldc_cfg_t             cfg_next;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_GAIN_P:         cfg_next.gain_p            = $signed(pwdata);
                REG_GAIN_I:         cfg_next.gain_i            = $signed(pwdata);
                REG_GAIN_D:         cfg_next.gain_d            = $signed(pwdata);
                REG_OUTPUT_LIMIT:   cfg_next.output_limit      = pwdata[LIMIT_W-1:0];
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit    = pwdata[LIMIT_W-1:0];
                REG_DEADBAND:       cfg_next.deadband          = pwdata[LIMIT_W-1:0];
                REG_ANGLE_WRAP:     cfg_next.angle_wrap_enable = pwdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GAIN_P:         prdata = cfg_reg.gain_p;
            REG_GAIN_I:         prdata = cfg_reg.gain_i;
            REG_GAIN_D:         prdata = cfg_reg.gain_d;
            REG_OUTPUT_LIMIT:   prdata = {{(CFG_DATA_W-LIMIT_W){1'b0}}, cfg_reg.output_limit};
            REG_INTEGRAL_LIMIT: prdata = {{(CFG_DATA_W-LIMIT_W){1'b0}}, cfg_reg.integral_limit};
            REG_DEADBAND:       prdata = {{(CFG_DATA_W-LIMIT_W){1'b0}}, cfg_reg.deadband};
            REG_ANGLE_WRAP:     prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_reg.angle_wrap_enable};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p            <= '0;
            cfg_reg.gain_i            <= '0;
            cfg_reg.gain_d            <= '0;
            cfg_reg.output_limit      <= OUTPUT_LIMIT_RST;
            cfg_reg.integral_limit    <= INTEGRAL_LIMIT_RST;
            cfg_reg.deadband          <= DEADBAND_RST;
            cfg_reg.angle_wrap_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: design/pldc_error.sv
`timescale 1ns / 1ps

module pldc_error #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic signed [pldc_pkg::FIELD_W-1:0] measure,
    input  logic signed [pldc_pkg::FIELD_W-1:0] target,
    input  logic                                wrap_en,
    input  logic [pldc_pkg::LIMIT_W-1:0]        deadband,
    output logic signed [DATA_WIDTH-1:0]        err,
    output logic                                in_band
);
    import pldc_pkg::*;

    // Wide enough for the raw difference, a full turn and the data range
    localparam int W_A   = (DATA_WIDTH + 1 > FIELD_W + 2) ? DATA_WIDTH + 1 : FIELD_W + 2;
    localparam int ERR_W = (FRAC_BITS + 11 > W_A) ? FRAC_BITS + 11 : W_A;
    localparam int HALF_TURN_DEG = 180;

    localparam logic signed [ERR_W-1:0] HALF_TURN = ERR_W'(HALF_TURN_DEG) <<< FRAC_BITS;
    localparam logic signed [ERR_W-1:0] FULL_TURN = HALF_TURN <<< 1;
    localparam logic signed [ERR_W-1:0] D_MAX =
        ERR_W'($signed({1'b0, {(DATA_WIDTH-1){1'b1}}}));
    localparam logic signed [ERR_W-1:0] D_MIN = -D_MAX - ERR_W'(1);

    logic signed [ERR_W-1:0] diff;
    logic signed [ERR_W-1:0] fold_hi;
    logic signed [ERR_W-1:0] fold_lo;
    logic signed [ERR_W-1:0] sat;
    logic signed [ERR_W-1:0] mag;
    logic signed [ERR_W-1:0] band;

    always_comb
    begin
        diff = ERR_W'(target) - ERR_W'(measure);

        // Fold the high side first, then the low side, once each
        fold_hi = (wrap_en && (diff >= HALF_TURN)) ? diff - FULL_TURN : diff;
        fold_lo = (wrap_en && (fold_hi <= -HALF_TURN)) ? fold_hi + FULL_TURN : fold_hi;

        if (fold_lo > D_MAX)
            sat = D_MAX;
        else if (fold_lo < D_MIN)
            sat = D_MIN;
        else
            sat = fold_lo;

        mag     = (sat < 0) ? -sat : sat;
        band    = ERR_W'($signed({1'b0, deadband}));
        in_band = !(mag > band);
        err     = DATA_WIDTH'(sat);
    end

endmodule

FILE: design/pldc_term.sv
`timescale 1ns / 1ps

module pldc_term #(
    parameter int OPER_W    = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic signed [pldc_pkg::GAIN_W-1:0] gain,
    input  logic signed [OPER_W-1:0]           oper,
    output logic signed [pldc_pkg::TERM_W-1:0] term
);
    import pldc_pkg::*;

    localparam int PROD_W = GAIN_W + OPER_W;
    localparam int CMP_W  = (PROD_W > TERM_W + 1) ? PROD_W : TERM_W + 1;
    localparam logic signed [CMP_W-1:0] LIM_POS = CMP_W'(TERM_LIM);
    localparam logic signed [CMP_W-1:0] LIM_NEG = -LIM_POS;

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] scaled;
    logic signed [CMP_W-1:0]  wide;

    always_comb
    begin
        prod   = PROD_W'(gain) * PROD_W'(oper);
        // arithmetic shift floors toward minus infinity
        scaled = prod >>> FRAC_BITS;
        wide   = CMP_W'(scaled);
        if (wide > LIM_POS)
            term = TERM_LIM;
        else if (wide < LIM_NEG)
            term = -TERM_LIM;
        else
            term = TERM_W'(wide);
    end

endmodule

FILE: design/pid_loop_deadband_clamp.sv
// Path: an accepted transaction is held in the input register and then written to the
// result register, from which the receiver takes it; a stalled output can hold it back.
// Throughput: one transaction per cycle, sustained, while the output is not stalled.
// Rate is set by the integral update, which reads the registered error and writes the integral register directly.
// Reset (rst_n low, asynchronous): valids drop, previous error/integral/drive clear to zero,
// gains clear, limits and deadband return to 13000.0, 1000.0 and 10.0, wrap off.
`timescale 1ns / 1ps

module pid_loop_deadband_clamp #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pldc_pkg::ADDR_W-1:0]       paddr,
    input  logic [pldc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [pldc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    // sample channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [pldc_pkg::FIELD_W-1:0] measure,
    input  logic signed [pldc_pkg::FIELD_W-1:0] target,
    // drive channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [pldc_pkg::FIELD_W-1:0] drive,
    output logic                              held
);
    import pldc_pkg::*;

    localparam int DIFF_W = DATA_WIDTH + 1;
    localparam int ISUM_W = TERM_W + 1;
    localparam int SUM_W  = TERM_W + 2;

    localparam logic signed [ISUM_W-1:0] I_DMAX =
        ISUM_W'($signed({1'b0, {(DATA_WIDTH-1){1'b1}}}));
    localparam logic signed [ISUM_W-1:0] I_DMIN = -I_DMAX - ISUM_W'(1);
    localparam logic signed [SUM_W-1:0]  S_DMAX =
        SUM_W'($signed({1'b0, {(DATA_WIDTH-1){1'b1}}}));
    localparam logic signed [SUM_W-1:0]  S_DMIN = -S_DMAX - SUM_W'(1);

    pldc_cfg_t cfg;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    pldc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Input stage: form, fold and saturate the error and test the deadband
    // before the input register. None of this depends on loop state.
    // ------------------------------------------------------------------
    logic signed [DATA_WIDTH-1:0] err_in;
    logic                         band_in;

    pldc_error #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_error (
        .measure  (measure),
        .target   (target),
        .wrap_en  (cfg.angle_wrap_enable),
        .deadband (cfg.deadband),
        .err      (err_in),
        .in_band  (band_in)
    );

    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic signed [DATA_WIDTH-1:0] s1_err_reg;
    logic signed [DATA_WIDTH-1:0] s1_err_next;
    logic                         s1_held_reg;
    logic                         s1_held_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         held_reg;
    logic                         held_next;

    // loop state; drive_value_reg doubles as the result payload
    logic signed [DATA_WIDTH-1:0] prev_err_reg;
    logic signed [DATA_WIDTH-1:0] prev_err_next;
    logic signed [DATA_WIDTH-1:0] integral_reg;
    logic signed [DATA_WIDTH-1:0] integral_next;
    logic signed [DATA_WIDTH-1:0] drive_value_reg;
    logic signed [DATA_WIDTH-1:0] drive_value_next;

    logic in_accept;
    logic s2_ready;
    logic s1_advance;

    // The result register takes a new transaction when it is empty or being
    // drained this cycle; the input register only stalls behind it.
    assign s2_ready   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && s2_ready;
    assign in_stall   = s1_valid_reg && !s2_ready;
    assign in_accept  = in_valid && !in_stall;

    assign s1_err_next  = err_in;
    assign s1_held_next = band_in;

    always_comb
    begin
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // ------------------------------------------------------------------
    // Update stage: three scaled products, integral clamp, output clamp
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] err_diff;
    logic signed [TERM_W-1:0] term_p;
    logic signed [TERM_W-1:0] term_i;
    logic signed [TERM_W-1:0] term_d;

    // exact difference, one bit wider than the data
    assign err_diff = DIFF_W'(s1_err_reg) - DIFF_W'(prev_err_reg);

    pldc_term #(
        .OPER_W    (DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_term_p (
        .gain (cfg.gain_p),
        .oper (s1_err_reg),
        .term (term_p)
    );

    pldc_term #(
        .OPER_W    (DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_term_i (
        .gain (cfg.gain_i),
        .oper (s1_err_reg),
        .term (term_i)
    );

    pldc_term #(
        .OPER_W    (DIFF_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_term_d (
        .gain (cfg.gain_d),
        .oper (err_diff),
        .term (term_d)
    );

    logic signed [ISUM_W-1:0]     isum_raw;
    logic signed [ISUM_W-1:0]     ilim_pos;
    logic signed [ISUM_W-1:0]     ilim_neg;
    logic signed [ISUM_W-1:0]     isum_lim;
    logic signed [ISUM_W-1:0]     isum_sat;
    logic signed [DATA_WIDTH-1:0] isum_fin;
    logic signed [SUM_W-1:0]      sum_raw;
    logic signed [SUM_W-1:0]      olim_pos;
    logic signed [SUM_W-1:0]      olim_neg;
    logic signed [SUM_W-1:0]      sum_lim;
    logic signed [SUM_W-1:0]      sum_sat;
    logic signed [DATA_WIDTH-1:0] sum_fin;

    always_comb
    begin
        // integral: accumulate, clamp to the integral limit, then to the data range
        isum_raw = ISUM_W'(term_i) + ISUM_W'(integral_reg);
        ilim_pos = ISUM_W'($signed({1'b0, cfg.integral_limit}));
        ilim_neg = -ilim_pos;
        if (isum_raw > ilim_pos)
            isum_lim = ilim_pos;
        else if (isum_raw < ilim_neg)
            isum_lim = ilim_neg;
        else
            isum_lim = isum_raw;
        if (isum_lim > I_DMAX)
            isum_sat = I_DMAX;
        else if (isum_lim < I_DMIN)
            isum_sat = I_DMIN;
        else
            isum_sat = isum_lim;
        isum_fin = DATA_WIDTH'(isum_sat);

        // drive: P + I + D, clamp to the output limit, then to the data range
        sum_raw  = SUM_W'(term_p) + SUM_W'(isum_fin) + SUM_W'(term_d);
        olim_pos = SUM_W'($signed({1'b0, cfg.output_limit}));
        olim_neg = -olim_pos;
        if (sum_raw > olim_pos)
            sum_lim = olim_pos;
        else if (sum_raw < olim_neg)
            sum_lim = olim_neg;
        else
            sum_lim = sum_raw;
        if (sum_lim > S_DMAX)
            sum_sat = S_DMAX;
        else if (sum_lim < S_DMIN)
            sum_sat = S_DMIN;
        else
            sum_sat = sum_lim;
        sum_fin = DATA_WIDTH'(sum_sat);
    end

    // The previous error always advances; integral and drive hold inside the deadband.
    always_comb
    begin
        prev_err_next    = prev_err_reg;
        integral_next    = integral_reg;
        drive_value_next = drive_value_reg;
        held_next        = held_reg;
        if (s1_advance)
        begin
            prev_err_next = s1_err_reg;
            held_next     = s1_held_reg;
            if (!s1_held_reg)
            begin
                integral_next    = isum_fin;
                drive_value_next = sum_fin;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            prev_err_reg    <= '0;
            integral_reg    <= '0;
            drive_value_reg <= '0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            prev_err_reg    <= prev_err_next;
            integral_reg    <= integral_next;
            drive_value_reg <= drive_value_next;
        end
    end

    // payload registers: load on their handshake only
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_err_reg  <= s1_err_next;
            s1_held_reg <= s1_held_next;
        end
        held_reg <= held_next;
    end

    assign out_valid = out_valid_reg;
    assign held      = held_reg;
    assign drive     = FIELD_W'(drive_value_reg);

`ifndef SYNTHESIS
    a_held_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_held_reg |=>
            held && $stable(drive_value_reg) && $stable(integral_reg))
        else $error("held transaction changed drive or integral");

    a_integral_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && !s1_held_reg |=>
            (integral_reg <= $signed({1'b0, cfg.integral_limit})) &&
            (integral_reg >= -$signed({1'b0, cfg.integral_limit})))
        else $error("integral outside its limit after update");

    a_drive_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && !s1_held_reg |=>
            (drive_value_reg <= $signed({1'b0, cfg.output_limit})) &&
            (drive_value_reg >= -$signed({1'b0, cfg.output_limit})))
        else $error("drive outside its limit after update");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall && s1_valid_reg)
        else $error("input stalled without a blocked result");

    a_prev_err_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> prev_err_reg == $past(s1_err_reg))
        else $error("previous error not taken from the advancing transaction");
`endif

endmodule
